[sv/tvt_pkg.sv]
// ----------------------------------------------------------------------------
// tvt_pkg: shared types and constants for two-view point triangulation
// Widths of the linear system terms, the back-end step program and the
// queue payload carried from the front end to the solver.
// ----------------------------------------------------------------------------
package tvt_pkg;

    localparam int NUM_CFG    = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_W      = 64;
    localparam int PIX_W      = 16;
    localparam int LANE_W     = 16;
    localparam int COORD_W    = 32;

    // Row terms of the 4x3 system, normal-equation terms, cofactors, wide accumulator
    localparam int AB_W       = 34;
    localparam int NR_W       = 70;
    localparam int OPB_W      = 72;
    localparam int ADJ_W      = 144;
    localparam int ACC_W      = 256;

    // Multiply-accumulate: one 8-bit slice of the narrow operand per cycle
    localparam int CHUNK_W    = 8;
    localparam int NUM_CHUNKS = OPB_W / CHUNK_W;
    localparam int NUM_STEPS  = 30;
    localparam int STEP_W     = 5;
    localparam int DIV_BITS   = 33;

    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = 1;

    typedef enum logic [1:0] {
        DEST_ADJ,
        DEST_DET,
        DEST_NUM
    } dest_t;

    // One product of the solver program
    typedef struct packed {
        logic       a_adj;   // wide operand is a cofactor, else a normal-matrix entry
        logic [3:0] a_idx;
        logic       b_r;     // narrow operand is a right-hand-side entry
        logic [2:0] b_idx;
        logic       neg;     // subtract the product
        logic       first;   // start a fresh sum
        logic       last;    // sum complete, store it
        dest_t      dest;
        logic [3:0] d_idx;
    } step_t;

    // Normal matrix (upper triangle n00,n01,n02,n11,n12,n22) and right-hand side
    typedef struct packed {
        logic [5:0][NR_W-1:0] n;
        logic [2:0][NR_W-1:0] r;
    } nr_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // Index of symmetric entry (i,j) in the upper-triangle list
    function automatic logic [2:0] n_index(int i, int j);
        int lo;
        int hi;
        lo = (i < j) ? i : j;
        hi = (i < j) ? j : i;
        if (lo == 0) begin
            return 3'(hi);
        end
        else if (lo == 1) begin
            return 3'(2 + hi);
        end
        return 3'd5;
    endfunction

    // Solver program: 18 cofactor products, 3 determinant products, 9 numerator products
    function automatic step_t step_entry(int s);
        step_t e;
        int ent;
        int i;
        int j;
        int k;
        int i1;
        int i2;
        int j1;
        int j2;
        e = '0;
        if (s < 18) begin
            ent = s / 2;
            i   = ent / 3;
            j   = ent % 3;
            i1  = (i + 1) % 3;
            i2  = (i + 2) % 3;
            j1  = (j + 1) % 3;
            j2  = (j + 2) % 3;
            if (s % 2 == 0) begin
                e.a_idx = 4'(n_index(j1, i1));
                e.b_idx = n_index(j2, i2);
                e.first = 1'b1;
            end
            else begin
                e.a_idx = 4'(n_index(j1, i2));
                e.b_idx = n_index(j2, i1);
                e.neg   = 1'b1;
                e.last  = 1'b1;
            end
            e.dest  = DEST_ADJ;
            e.d_idx = 4'(ent);
        end
        else if (s < 21) begin
            k       = s - 18;
            e.a_adj = 1'b1;
            e.a_idx = 4'(3 * k);
            e.b_idx = n_index(0, k);
            e.first = (k == 0);
            e.last  = (k == 2);
            e.dest  = DEST_DET;
        end
        else begin
            k       = s - 21;
            i       = k / 3;
            j       = k % 3;
            e.a_adj = 1'b1;
            e.a_idx = 4'(3 * i + j);
            e.b_r   = 1'b1;
            e.b_idx = 3'(j);
            e.first = (j == 0);
            e.last  = (j == 2);
            e.dest  = DEST_NUM;
            e.d_idx = 4'(i);
        end
        return e;
    endfunction

endpackage

[sv/two_view_point_triangulation.sv]
// ----------------------------------------------------------------------------
// two_view_point_triangulation: linear two-view triangulation
// Flow per point: 2 builder stages, then on the shared 144x8 multiply-accumulate
// 18 cofactor and 3 determinant products (then straight to output when the system
// is singular), and per axis 3 products, a setup state and a restoring divider.
// The solver takes a new point only once it has output the last one; the builder
// and a 2-entry queue take new points while the solver works.
// Reset: asynchronous active-low; clears configuration to zero and empties the pipe.
// ----------------------------------------------------------------------------
module two_view_point_triangulation
    import tvt_pkg::*;
#(
    parameter int OUTPUT_FRAC_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [63:0]          s_axis_tdata,   // pixel_u_a, pixel_v_a, pixel_u_b, pixel_v_b
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [95:0]          m_axis_tdata,   // point_x, point_y, point_z
    output logic                 m_axis_tuser    // singular
);

    logic [CFG_W-1:0]          cfg_reg [NUM_CFG];
    q_stat_t                   q_stat;
    logic                      q_push, q_pop;
    nr_t                       q_in, q_out;
    logic signed [COORD_W-1:0] point_x, point_y, point_z;

    assign cfg_ready = 1'b1;

    // Hold configuration; ignore writes beyond the register list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CFG; i++)
            begin
                cfg_reg[i] <= '0;
            end
        end
        else if (cfg_valid && cfg_index < CFG_IDX_W'(NUM_CFG))
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    tvt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .pixel_u_a (s_axis_tdata[15:0]),
        .pixel_v_a (s_axis_tdata[31:16]),
        .pixel_u_b (s_axis_tdata[47:32]),
        .pixel_v_b (s_axis_tdata[63:48]),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    tvt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .stat      (q_stat)
    );

    tvt_back #(
        .OUT_FRAC_BITS (OUTPUT_FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_stat       (q_stat),
        .q_data       (q_out),
        .q_pop        (q_pop),
        .out_ready    (m_axis_tready),
        .out_valid    (m_axis_tvalid),
        .out_x        (point_x),
        .out_y        (point_y),
        .out_z        (point_z),
        .out_singular (m_axis_tuser)
    );

    assign m_axis_tdata = {point_z, point_y, point_x};

    // A singular result always carries a zero point
    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("singular result with nonzero point");

    // Input stalls only when the builder is backed up by a full queue
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> q_stat.full)
        else $error("input stalled with room in the queue");

    // The solver never pops an empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("pop from empty queue");

endmodule

[sv/tvt_front.sv]
// ----------------------------------------------------------------------------
// tvt_front: system builder
// Two pipeline stages: the four rows of the linear system from pixels,
// intrinsics and poses, then the normal matrix and right-hand side.
// ----------------------------------------------------------------------------
module tvt_front
    import tvt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [CFG_W-1:0]    cfg [NUM_CFG],
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [PIX_W-1:0]    pixel_u_a,
    input  logic [PIX_W-1:0]    pixel_v_a,
    input  logic [PIX_W-1:0]    pixel_u_b,
    input  logic [PIX_W-1:0]    pixel_v_b,
    input  q_stat_t             q_stat,
    output logic                q_push,
    output nr_t                 q_data
);

    logic signed [LANE_W-1:0] pose [2][12];
    logic [PIX_W-1:0]         pu [2];
    logic [PIX_W-1:0]         pv [2];
    logic signed [PIX_W:0]    fxs, fys;
    logic signed [PIX_W:0]    dcx [2];
    logic signed [PIX_W:0]    dcy [2];
    logic signed [AB_W-1:0]   a_c [4][3];
    logic signed [AB_W-1:0]   b_c [4];
    logic signed [AB_W-1:0]   a_reg [4][3];
    logic signed [AB_W-1:0]   b_reg [4];
    logic                     v1_reg, v2_reg;
    logic signed [2*AB_W-1:0] pn [6][4];
    logic signed [2*AB_W-1:0] pr [3][4];
    logic signed [NR_W-1:0]   n_c [6];
    logic signed [NR_W-1:0]   r_c [3];
    nr_t                      nr_reg;
    logic                     advance;

    assign pu[0] = pixel_u_a;
    assign pv[0] = pixel_v_a;
    assign pu[1] = pixel_u_b;
    assign pv[1] = pixel_v_b;
    assign fxs   = $signed({1'b0, cfg[0][15:0]});
    assign fys   = $signed({1'b0, cfg[0][31:16]});

    // Unpack pose lanes of both views
    always_comb
    begin
        for (int v = 0; v < 2; v++)
        begin
            for (int m = 0; m < 12; m++)
            begin
                pose[v][m] = $signed(cfg[1 + 3 * v + (m >> 2)][LANE_W * (m & 3) +: LANE_W]);
            end
        end
    end

    // Build two rows per view
    always_comb
    begin
        for (int v = 0; v < 2; v++)
        begin
            dcx[v] = $signed({1'b0, cfg[0][47:32]}) - $signed({1'b0, pu[v]});
            dcy[v] = $signed({1'b0, cfg[0][63:48]}) - $signed({1'b0, pv[v]});
            for (int k = 0; k < 3; k++)
            begin
                a_c[2 * v][k]     = fxs * pose[v][k] + dcx[v] * pose[v][6 + k];
                a_c[2 * v + 1][k] = fys * pose[v][3 + k] + dcy[v] * pose[v][6 + k];
            end
            b_c[2 * v]     = -(dcx[v] * pose[v][11]) - fxs * pose[v][9];
            b_c[2 * v + 1] = -(dcy[v] * pose[v][11]) - fys * pose[v][10];
        end
    end

    // Normal matrix and right-hand side from the registered rows
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                pr[i][k] = a_reg[k][i] * b_reg[k];
            end
            for (int j = i; j < 3; j++)
            begin
                for (int k = 0; k < 4; k++)
                begin
                    pn[n_index(i, j)][k] = a_reg[k][i] * a_reg[k][j];
                end
            end
        end
        for (int e = 0; e < 6; e++)
        begin
            n_c[e] = NR_W'(pn[e][0]) + NR_W'(pn[e][1]) + NR_W'(pn[e][2]) + NR_W'(pn[e][3]);
        end
        for (int i = 0; i < 3; i++)
        begin
            r_c[i] = NR_W'(pr[i][0]) + NR_W'(pr[i][1]) + NR_W'(pr[i][2]) + NR_W'(pr[i][3]);
        end
    end

    // Advance the pipe unless the last stage is held by a full queue
    assign advance  = !v2_reg || !q_stat.full;
    assign in_ready = advance;
    assign q_push   = v2_reg && !q_stat.full;
    assign q_data   = nr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_reg <= a_c;
            b_reg <= b_c;
            for (int e = 0; e < 6; e++)
            begin
                nr_reg.n[e] <= n_c[e];
            end
            for (int i = 0; i < 3; i++)
            begin
                nr_reg.r[i] <= r_c[i];
            end
        end
    end

endmodule

[sv/tvt_queue.sv]
// ----------------------------------------------------------------------------
// tvt_queue: decoupling queue
// Short FIFO of normal-equation sets between the builder and the solver.
// ----------------------------------------------------------------------------
module tvt_queue
    import tvt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  nr_t     push_data,
    input  logic    pop,
    output nr_t     pop_data,
    output q_stat_t stat
);

    nr_t                mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_PTR_W:0]   count_reg;
    logic               push_ok, pop_ok;

    assign stat.full  = (count_reg == (Q_PTR_W + 1)'(Q_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign push_ok    = push && !stat.full;
    assign pop_ok     = pop && !stat.empty;
    assign pop_data   = mem[rd_ptr_reg];

    // Track pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_ok)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop_ok)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push_ok, pop_ok})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[sv/tvt_back.sv]
// ----------------------------------------------------------------------------
// tvt_back: normal-equation solver
// Shared 144x8 multiply-accumulate runs the cofactor, determinant and
// numerator program; a restoring divider rounds and saturates each axis.
// ----------------------------------------------------------------------------
module tvt_back
    import tvt_pkg::*;
#(
    parameter int OUT_FRAC_BITS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  q_stat_t                   q_stat,
    input  nr_t                       q_data,
    output logic                      q_pop,
    input  logic                      out_ready,
    output logic                      out_valid,
    output logic signed [COORD_W-1:0] out_x,
    output logic signed [COORD_W-1:0] out_y,
    output logic signed [COORD_W-1:0] out_z,
    output logic                      out_singular
);

    localparam int NUM_SHIFT = OUT_FRAC_BITS + 3;
    localparam logic [1:0] LAST_COORD = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_DABS,
        S_PREP,
        S_DIV,
        S_OUT
    } state_t;

    state_t                     state_reg;
    logic [STEP_W-1:0]          step_reg;
    logic [3:0]                 chunk_reg;
    logic [5:0]                 cnt_reg;
    logic                       out_valid_reg;

    step_t                      step_tab [NUM_STEPS];
    step_t                      cur;
    logic signed [NR_W-1:0]     na_reg [6];
    logic signed [NR_W-1:0]     nb_reg [6];
    logic signed [NR_W-1:0]     r_reg [3];
    logic signed [ADJ_W-1:0]    adj_reg [9];
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    det_reg;
    logic [ACC_W-1:0]           det_abs_reg;
    logic                       det_neg_reg;
    logic signed [ACC_W-1:0]    num_reg;
    logic [1:0]                 coord_idx_reg;
    logic [ACC_W-1:0]           rem_reg;
    logic [ACC_W-1:0]           dsh_reg;
    logic [DIV_BITS-1:0]        q_reg;
    logic                       big_reg;
    logic signed [COORD_W-1:0]  coord_reg [3];
    logic                       sing_reg;
    logic signed [COORD_W-1:0]  out_x_reg, out_y_reg, out_z_reg;
    logic                       out_sing_reg;

    logic signed [ADJ_W-1:0]    a_val;
    logic signed [OPB_W-1:0]    b_val;
    logic [CHUNK_W-1:0]         b_byte;
    logic signed [CHUNK_W:0]    m_op;
    logic signed [ADJ_W+CHUNK_W:0] prod;
    logic signed [ACC_W-1:0]    shifted;
    logic signed [ACC_W-1:0]    acc_base;
    logic signed [ACC_W-1:0]    acc_sum;
    logic                       mac_done;
    logic                       det_zero;
    logic [ACC_W-1:0]           prep_val;
    logic                       div_ge;
    logic [DIV_BITS-1:0]        q_fin;
    logic                       res_neg;
    logic signed [COORD_W-1:0]  sat_val;
    logic                       out_load;

    for (genvar g = 0; g < NUM_STEPS; g++)
    begin : g_step
        assign step_tab[g] = step_entry(g);
    end

    // Multiply-accumulate datapath
    always_comb
    begin
        cur      = step_tab[step_reg];
        a_val    = cur.a_adj ? adj_reg[cur.a_idx] : ADJ_W'(na_reg[cur.a_idx[2:0]]);
        b_val    = cur.b_r ? OPB_W'(r_reg[cur.b_idx[1:0]]) : OPB_W'(nb_reg[cur.b_idx]);
        b_byte   = b_val[{chunk_reg, 3'b000} +: CHUNK_W];
        mac_done = (chunk_reg == 4'(NUM_CHUNKS - 1));
        m_op     = mac_done ? $signed({b_byte[CHUNK_W-1], b_byte}) : $signed({1'b0, b_byte});
        prod     = a_val * m_op;
        shifted  = ACC_W'(prod) <<< {chunk_reg, 3'b000};
        acc_base = (cur.first && chunk_reg == '0) ? '0 : acc_reg;
        acc_sum  = cur.neg ? acc_base - shifted : acc_base + shifted;
    end

    // Divider datapath: rounded quotient of 2|num|+|det| over 2|det|
    always_comb
    begin
        det_zero = (det_reg == '0);
        prep_val = ((num_reg[ACC_W-1] ? ~num_reg : num_reg) << 1) + det_abs_reg
                 + (num_reg[ACC_W-1] ? ACC_W'(2) : ACC_W'(0));
        div_ge   = (rem_reg >= dsh_reg);
        q_fin    = {q_reg[DIV_BITS-2:0], div_ge};
        res_neg  = num_reg[ACC_W-1] ^ det_neg_reg;
        if (res_neg)
        begin
            if (big_reg || q_fin > DIV_BITS'(33'h080000000))
            begin
                sat_val = 32'sh80000000;
            end
            else
            begin
                sat_val = $signed(32'h0 - q_fin[COORD_W-1:0]);
            end
        end
        else if (big_reg || q_fin[DIV_BITS-1] || q_fin[COORD_W-1])
        begin
            sat_val = 32'sh7FFFFFFF;
        end
        else
        begin
            sat_val = $signed(q_fin[COORD_W-1:0]);
        end
    end

    assign q_pop        = (state_reg == S_IDLE) && !q_stat.empty;
    assign out_load     = (state_reg == S_OUT) && (!out_valid_reg || out_ready);
    assign out_valid    = out_valid_reg;
    assign out_x        = out_x_reg;
    assign out_y        = out_y_reg;
    assign out_z        = out_z_reg;
    assign out_singular = out_sing_reg;

    // Sequencer state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            chunk_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (!q_stat.empty)
                    begin
                        state_reg <= S_MAC;
                        step_reg  <= '0;
                        chunk_reg <= '0;
                    end
                end
                S_MAC:
                begin
                    if (mac_done)
                    begin
                        chunk_reg <= '0;
                        step_reg  <= step_reg + 1'b1;
                        if (cur.last && cur.dest == DEST_DET)
                        begin
                            state_reg <= S_DABS;
                        end
                        else if (cur.last && cur.dest == DEST_NUM)
                        begin
                            state_reg <= S_PREP;
                        end
                    end
                    else
                    begin
                        chunk_reg <= chunk_reg + 1'b1;
                    end
                end
                S_DABS:
                begin
                    state_reg <= det_zero ? S_OUT : S_MAC;
                end
                S_PREP:
                begin
                    state_reg <= S_DIV;
                    cnt_reg   <= 6'(DIV_BITS);
                end
                S_DIV:
                begin
                    if (cnt_reg == '0)
                    begin
                        state_reg <= (coord_idx_reg == LAST_COORD) ? S_OUT : S_MAC;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Solver payload registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    for (int e = 0; e < 6; e++)
                    begin
                        na_reg[e] <= $signed(q_data.n[e]);
                        nb_reg[e] <= $signed(q_data.n[e]);
                    end
                    for (int i = 0; i < 3; i++)
                    begin
                        r_reg[i] <= $signed(q_data.r[i]);
                    end
                    sing_reg <= 1'b0;
                end
            end
            S_MAC:
            begin
                acc_reg <= acc_sum;
                if (mac_done && cur.last)
                begin
                    case (cur.dest)
                        DEST_ADJ: adj_reg[cur.d_idx] <= acc_sum[ADJ_W-1:0];
                        DEST_DET: det_reg <= acc_sum;
                        DEST_NUM:
                        begin
                            num_reg       <= acc_sum <<< NUM_SHIFT;
                            coord_idx_reg <= cur.d_idx[1:0];
                        end
                        default: ;
                    endcase
                end
            end
            S_DABS:
            begin
                det_neg_reg <= det_reg[ACC_W-1];
                det_abs_reg <= det_reg[ACC_W-1] ? -det_reg : det_reg;
                if (det_zero)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        coord_reg[i] <= '0;
                    end
                    sing_reg <= 1'b1;
                end
            end
            S_PREP:
            begin
                rem_reg <= prep_val;
                dsh_reg <= det_abs_reg << (DIV_BITS + 1);
            end
            S_DIV:
            begin
                // Top trial flags a quotient too large for any coordinate
                if (cnt_reg == 6'(DIV_BITS))
                begin
                    big_reg <= div_ge;
                end
                else
                begin
                    if (div_ge)
                    begin
                        rem_reg <= rem_reg - dsh_reg;
                    end
                    q_reg <= q_fin;
                end
                dsh_reg <= dsh_reg >> 1;
                if (cnt_reg == '0)
                begin
                    coord_reg[coord_idx_reg] <= sat_val;
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    out_x_reg    <= coord_reg[0];
                    out_y_reg    <= coord_reg[1];
                    out_z_reg    <= coord_reg[2];
                    out_sing_reg <= sing_reg;
                end
            end
            default: ;
        endcase
    end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for two_view_point_triangulation
// Streams matched pixel pairs through the triangulator under several camera
// setups and checks every returned point against an exact big-integer solve
// of the normal equations, with random idling on both stream sides.
// ----------------------------------------------------------------------------
module tb_top;
    import tvt_pkg::*;

    localparam int  OUT_FRAC   = 16;
    localparam int  CYCLE_CAP  = 6000000;
    localparam int  DRAIN_WAIT = 500;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INTRINSICS = 3'd0,
        REG_POSE_A0    = 3'd1,
        REG_POSE_A1    = 3'd2,
        REG_POSE_A2    = 3'd3,
        REG_POSE_B0    = 3'd4,
        REG_POSE_B1    = 3'd5,
        REG_POSE_B2    = 3'd6,
        REG_SPARE      = 3'd7
    } reg_idx_t;

    typedef logic signed [255:0] big_t;

    typedef struct {
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic        sing;
    } point_t;

    // ------------------------------------------------------------------------
    // Point predictor and store of expected points
    // ------------------------------------------------------------------------
    class point_scoreboard;
        logic [63:0] regs [NUM_CFG];
        point_t      expected_pts [$];
        int          errors;
        int          n_points;
        int          n_singular;
        int          n_saturated;

        function new();
            foreach (regs[i]) regs[i] = '0;
            errors = 0;
            n_points = 0;
            n_singular = 0;
            n_saturated = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
            if (idx < NUM_CFG)
                regs[idx] = val;
        endfunction

        function longint lane_u(logic [63:0] w, int l);
            return longint'({48'd0, w[16*l +: 16]});
        endfunction

        function longint lane_s(logic [63:0] w, int l);
            return longint'($signed(w[16*l +: 16]));
        endfunction

        // Round to nearest (ties away from zero) and saturate to 32 bits
        function logic [31:0] scale_point(big_t num, big_t det);
            logic         neg;
            logic [255:0] an;
            logic [255:0] ad;
            logic [255:0] q;
            neg = num[255] ^ det[255];
            an  = num[255] ? -num : num;
            ad  = det[255] ? -det : det;
            q   = ((an << 1) + ad) / (ad << 1);
            if (neg) begin
                if (q > 256'h8000_0000)
                    return 32'h8000_0000;
                return -q[31:0];
            end
            if (q > 256'h7FFF_FFFF)
                return 32'h7FFF_FFFF;
            return q[31:0];
        endfunction

        // Build the 4x3 system from one transfer and queue the solved point
        function void note_pixels(logic [63:0] pix);
            longint a [4][3];
            longint b [4];
            longint fx, fy, cx, cy, u, v;
            longint p [12];
            big_t   nm [3][3];
            big_t   rh [3];
            big_t   adj [3][3];
            big_t   det;
            big_t   num;
            point_t pt;
            fx = lane_u(regs[REG_INTRINSICS], 0);
            fy = lane_u(regs[REG_INTRINSICS], 1);
            cx = lane_u(regs[REG_INTRINSICS], 2);
            cy = lane_u(regs[REG_INTRINSICS], 3);
            for (int vw = 0; vw < 2; vw++) begin
                u = lane_u(pix, 2 * vw);
                v = lane_u(pix, 2 * vw + 1);
                for (int m = 0; m < 12; m++)
                    p[m] = lane_s(regs[1 + 3 * vw + m / 4], m % 4);
                for (int k = 0; k < 3; k++) begin
                    a[2*vw][k]   = fx * p[k] + (cx - u) * p[6+k];
                    a[2*vw+1][k] = fy * p[3+k] + (cy - v) * p[6+k];
                end
                b[2*vw]   = (u - cx) * p[11] - fx * p[9];
                b[2*vw+1] = (v - cy) * p[11] - fy * p[10];
            end
            for (int i = 0; i < 3; i++) begin
                rh[i] = '0;
                for (int k = 0; k < 4; k++)
                    rh[i] += big_t'(a[k][i]) * big_t'(b[k]);
                for (int j = 0; j < 3; j++) begin
                    nm[i][j] = '0;
                    for (int k = 0; k < 4; k++)
                        nm[i][j] += big_t'(a[k][i]) * big_t'(a[k][j]);
                end
            end
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    adj[i][j] = nm[(j+1)%3][(i+1)%3] * nm[(j+2)%3][(i+2)%3]
                              - nm[(j+1)%3][(i+2)%3] * nm[(j+2)%3][(i+1)%3];
            det = '0;
            for (int k = 0; k < 3; k++)
                det += nm[0][k] * adj[k][0];
            if (det == 0) begin
                pt = '{32'd0, 32'd0, 32'd0, 1'b1};
            end
            else begin
                logic [31:0] c [3];
                for (int i = 0; i < 3; i++) begin
                    num = '0;
                    for (int j = 0; j < 3; j++)
                        num += adj[i][j] * rh[j];
                    num = num <<< (OUT_FRAC + 3);
                    c[i] = scale_point(num, det);
                end
                pt = '{c[0], c[1], c[2], 1'b0};
            end
            expected_pts = {expected_pts, pt};
        endfunction

        // Compare one returned point with the oldest expectation
        function void check_point(logic [95:0] data, logic sing);
            point_t e;
            if (expected_pts.size() == 0) begin
                $error("unexpected point transfer %h", data);
                errors++;
                return;
            end
            e = expected_pts.pop_front();
            n_points++;
            if (e.sing)
                n_singular++;
            if (e.px == 32'h7FFF_FFFF || e.px == 32'h8000_0000)
                n_saturated++;
            if (data[31:0] !== e.px) begin
                $error("point_x expected %h got %h", e.px, data[31:0]);
                errors++;
            end
            if (data[63:32] !== e.py) begin
                $error("point_y expected %h got %h", e.py, data[63:32]);
                errors++;
            end
            if (data[95:64] !== e.pz) begin
                $error("point_z expected %h got %h", e.pz, data[95:64]);
                errors++;
            end
            if (sing !== e.sing) begin
                $error("singular expected %0d got %0d", e.sing, sing);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [63:0]          s_axis_tdata;   // pixel_u_a, pixel_v_a, pixel_u_b, pixel_v_b
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [95:0]          m_axis_tdata;   // point_x, point_y, point_z
    logic                 m_axis_tuser;   // singular

    point_scoreboard sb;
    int  send_idle;
    int  recv_idle;
    int  hold_len = 0;
    int  hold_asks = 0;
    int  hold_taken = 0;
    int  cycle_cnt = 0;
    int  n_sent;

    two_view_point_triangulation #(.OUTPUT_FRAC_BITS(OUT_FRAC)) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // Drop the run at the cycle cap
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
        end
        else if (hold_len > 0) begin
            hold_len      <= hold_len - 1;
            m_axis_tready <= 1'b0;
        end
        else if (hold_taken != hold_asks) begin
            hold_taken    <= hold_asks;
            hold_len      <= 3000;
            m_axis_tready <= 1'b0;
        end
        else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Note accepted pixel pairs and check returned points
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_pixels(s_axis_tdata);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_point(m_axis_tdata, m_axis_tuser);
    end

    // Offer one pixel pair; valid stays up for a back-to-back follower
    task automatic send_pixels(logic [15:0] ua, logic [15:0] va,
                               logic [15:0] ub, logic [15:0] vb);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {vb, ub, va, ua};
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        n_sent++;
    endtask

    // Hold off until every expected point has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.expected_pts.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Rotation-like lanes near unit scale, translation within a few meters
    function automatic logic [15:0] rot_lane();
        return 16'($signed($urandom_range(32766)) - 16383);
    endfunction

    function automatic logic [15:0] t_lane();
        return 16'($signed($urandom_range(16000)) - 8000);
    endfunction

    task automatic write_pose(reg_idx_t w0, logic [15:0] l [12]);
        write_reg(w0,                 {l[3], l[2], l[1], l[0]});
        write_reg(reg_idx_t'(w0 + 1), {l[7], l[6], l[5], l[4]});
        write_reg(reg_idx_t'(w0 + 2), {l[11], l[10], l[9], l[8]});
    endtask

    // kind 0: plausible cameras, 1: fully random, 2: all-ones, 3: max positive lanes
    task automatic load_setup(int kind);
        logic [15:0] l [12];
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        case (kind)
            0:
            begin
                write_reg(REG_INTRINSICS, {16'($urandom_range(200, 600) << 4),
                                           16'($urandom_range(200, 400) << 4),
                                           16'($urandom_range(300, 900) << 4),
                                           16'($urandom_range(300, 900) << 4)});
                for (int vw = 0; vw < 2; vw++) begin
                    for (int m = 0; m < 9; m++)
                        l[m] = rot_lane();
                    for (int m = 9; m < 11; m++)
                        l[m] = t_lane();
                    l[11] = 16'($urandom_range(2048, 16000));
                    write_pose(vw ? REG_POSE_B0 : REG_POSE_A0, l);
                end
            end
            1:
            begin
                write_reg(REG_INTRINSICS, rand64());
                for (int r = REG_POSE_A0; r <= REG_POSE_B2; r++)
                    write_reg(reg_idx_t'(r), rand64());
            end
            2:
            begin
                for (int r = REG_INTRINSICS; r <= REG_POSE_B2; r++)
                    write_reg(reg_idx_t'(r), '1);
            end
            default:
            begin
                write_reg(REG_INTRINSICS, '1);
                for (int r = REG_POSE_A0; r <= REG_POSE_B2; r++)
                    write_reg(reg_idx_t'(r), {4{16'h7FFF}});
            end
        endcase
    endtask

    // Mostly in-image pixels, the rest anywhere in the 16-bit range
    task automatic send_random();
        logic [15:0] c [4];
        if ($urandom_range(99) < 80) begin
            foreach (c[i])
                c[i] = 16'($urandom_range(16'h3FFF));
        end
        else begin
            foreach (c[i])
                c[i] = 16'($urandom());
        end
        send_pixels(c[0], c[1], c[2], c[3]);
    endtask

    initial
    begin
        logic [15:0] l [12];
        sb            = new();
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        send_idle     = 0;
        recv_idle     = 0;
        n_sent        = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Registers at reset: every point is singular
        send_pixels(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_pixels(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);

        // Stereo rig: identical intrinsics, view B shifted one meter along x
        wait_drained();
        write_reg(REG_INTRINSICS, {16'(240 << 4), 16'(320 << 4), 16'(500 << 4),
                                   16'(500 << 4)});
        foreach (l[i])
            l[i] = 16'd0;
        l[0] = 16'd16384;
        l[4] = 16'd16384;
        l[8] = 16'd16384;
        write_pose(REG_POSE_A0, l);
        l[9] = -16'sd2048;
        write_pose(REG_POSE_B0, l);
        // spare index is ignored by the block
        write_reg(REG_SPARE, rand64());
        send_pixels(16'(320 << 4), 16'(240 << 4), 16'(220 << 4), 16'(240 << 4));
        send_pixels(16'(400 << 4), 16'(100 << 4), 16'(350 << 4), 16'(100 << 4));
        send_pixels(16'(320 << 4), 16'(240 << 4), 16'(320 << 4), 16'(240 << 4));
        send_pixels(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_pixels(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixels(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
        send_pixels(16'(320 << 4), 16'(240 << 4), 16'(319 << 4), 16'(240 << 4));

        // Degenerate rig: view B equals view A, tiny disparity saturates
        wait_drained();
        l[9] = 16'd0;
        l[11] = 16'd1;
        write_pose(REG_POSE_A0, l);
        write_pose(REG_POSE_B0, l);
        send_pixels(16'(320 << 4), 16'(240 << 4), 16'(320 << 4), 16'(240 << 4));
        send_pixels(16'h1234, 16'h0FED, 16'h1235, 16'h0FED);

        // Extreme lanes
        load_setup(2);
        send_pixels(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
        send_pixels(16'h8000, 16'h7FFF, 16'h0001, 16'hFFFE);
        load_setup(3);
        send_pixels(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
        send_pixels(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);

        // Random part over three idling regimes
        for (int ph = 0; ph < 3; ph++) begin
            send_idle = (ph == 0) ? 35 : (ph == 1) ? 59 : 0;
            recv_idle = (ph == 0) ? 59 : (ph == 1) ? 35 : 0;
            for (int sub = 0; sub < 4; sub++) begin
                load_setup((sub == 1) ? 1 : (sub == 2 && ph == 2) ? 2 : 0);
                if (ph == 0 && sub == 0) begin
                    // long receiver hold-off while points keep coming
                    hold_asks <= hold_asks + 1;
                    repeat (12) send_random();
                end
                repeat (100) send_random();
            end
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("covered %0d pixel pairs, %0d points checked (%0d singular, %0d saturated x)",
                 n_sent, sb.n_points, sb.n_singular, sb.n_saturated);
        $display("setups: reset, stereo rig, degenerate rig, extreme and random cameras");
        if (sb.errors == 0 && sb.expected_pts.size() == 0) begin
            $display("RESULT: OK");
        end
        else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
sv/tvt_pkg.sv
sv/tvt_front.sv
sv/tvt_queue.sv
sv/tvt_back.sv
sv/two_view_point_triangulation.sv
tb/sv/tb_top.sv
